>>> rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;
  localparam int PAT_WORDS  = 4;
  localparam int LEN_W      = 6;
  localparam int OFF_W      = 32;
  localparam int ADDR_W     = 64;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_WILDCARD  = 3'd4,
    CFG_LENGTH    = 3'd5
  } cfg_reg_t;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [PAT_BYTES-1:0][BYTE_W-1:0] want;
    logic [PAT_BYTES-1:0]             care;
    logic [LEN_W-1:0]                 len;
  } pattern_t;

endpackage

>>> rtl/mbps_ifs.sv
// Valid/ready channel interfaces for byte items and search results.
interface mbps_in_if import mbps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic               first_byte;
  logic               last_byte;
  logic [ADDR_W-1:0]  region_base;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  output region_base, input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  input region_base, output ready);
endinterface

interface mbps_out_if import mbps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [ADDR_W-1:0]  match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

>>> rtl/mbps_cfg.sv
// Configuration registers and window-aligned pattern, care mask and clamped length.
module mbps_cfg import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output pattern_t             pat
);

  logic [PAT_WORDS-1:0][CFG_W-1:0]  pat_words_r;
  logic [PAT_BYTES-1:0]             wild_r;
  logic [LEN_W-1:0]                 len_r;
  logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
  logic [LEN_W-1:0]                 len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r <= '0;
      wild_r      <= '0;
      len_r       <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PAT_0_7:   pat_words_r[0] <= cfg_wdata;
        CFG_PAT_8_15:  pat_words_r[1] <= cfg_wdata;
        CFG_PAT_16_23: pat_words_r[2] <= cfg_wdata;
        CFG_PAT_24_31: pat_words_r[3] <= cfg_wdata;
        CFG_WILDCARD:  wild_r         <= cfg_wdata[PAT_BYTES-1:0];
        CFG_LENGTH:    len_r          <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_words_r;

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  // window entry j lines up with pattern byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] src;
    pat     = '0;
    pat.len = len_eff;
    for (int j = 0; j < PAT_BYTES; j++) begin
      src         = len_eff - LEN_W'(1) - LEN_W'(j);
      pat.want[j] = pat_bytes[src[PAT_IDX_W-1:0]];
      pat.care[j] = (LEN_W'(j) < len_eff) && !wild_r[src[PAT_IDX_W-1:0]];
    end
  end

endmodule

>>> rtl/mbps_match.sv
// Parallel masked compare of the byte window against the aligned pattern.
module mbps_match import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  pattern_t                          pat,
  input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window,
  output logic                              hit
);

  logic [MAX_PATTERN-1:0] pos_ok;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos_ok[j] = !pat.care[j] || (window[j] == pat.want[j]);
    end
  end

  assign hit = &pos_ok;

endmodule

>>> rtl/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search block.
//
// Usage: stream a region one byte per item on in_ch; mark its first byte with
// first_byte (region_base is taken then) and its final byte with last_byte.
// Each region gives one item on out_ch: found with region base plus match
// start offset at the first byte that completes a match, or not found with
// address 0 on the last byte. Bytes after that result, up to the next first
// byte, give nothing.
// Pattern, wildcard mask and length are to be written on the cfg_ port only
// while idle; the block itself does not enforce this. An item accepted on
// in_ch lands in the input register, is compared and folded into the scan
// state as it leaves, and any result it gives lands in the output register.
// The combinational compare takes one byte per cycle unless out_ch stalls.
// The input register takes a new byte while a result waits in the output
// register; a stalled receiver holds the result and, once the input register
// is full, drops in_ch.ready.
// Reset clears the window, offset, base, region state and both valid flags;
// the length register comes up as 1.
module masked_byte_pattern_search_top import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  mbps_in_if.sink              in_ch,
  mbps_out_if.source           out_ch
);

  pattern_t pat;

  logic              v1_r;
  byte_t             data1_r;
  logic              first1_r;
  logic              last1_r;
  logic [ADDR_W-1:0] base1_r;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_r;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_nxt;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_eff;
  logic [LEN_W-1:0]                   seen_r;
  logic [LEN_W-1:0]                   seen_nxt;
  logic [LEN_W-1:0]                   seen_eff;
  logic [OFF_W-1:0]                   off_r;
  logic [OFF_W-1:0]                   off_nxt;
  logic [OFF_W-1:0]                   off_eff;
  logic [ADDR_W-1:0]                  base_r;
  logic [ADDR_W-1:0]                  base_eff;
  logic                               done_r;
  logic                               done_nxt;
  logic                               done_eff;

  logic              live;
  logic              win_hit;
  logic              hit;
  logic              res_en;
  logic [OFF_W:0]    start_off;
  logic [ADDR_W-1:0] res_addr;

  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic out_free;
  logic adv1;
  logic in_ready;

  mbps_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pat       (pat)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign adv1     = v1_r && out_free;
  assign in_ready = !v1_r || adv1;

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      data1_r  <= in_ch.data_byte;
      first1_r <= in_ch.first_byte;
      last1_r  <= in_ch.last_byte;
      base1_r  <= in_ch.region_base;
    end
  end

  // first byte restarts the region before the byte is scanned
  always_comb begin
    if (first1_r) begin
      win_eff  = '0;
      seen_eff = '0;
      off_eff  = '0;
      base_eff = base1_r;
      done_eff = 1'b0;
    end else begin
      win_eff  = win_r;
      seen_eff = seen_r;
      off_eff  = off_r;
      base_eff = base_r;
      done_eff = done_r;
    end
  end

  assign live = !done_eff;

  always_comb begin
    win_nxt  = win_eff;
    seen_nxt = seen_eff;
    off_nxt  = off_eff;
    if (live) begin
      for (int j = MAX_PATTERN - 1; j > 0; j--) begin
        win_nxt[j] = win_eff[j-1];
      end
      win_nxt[0] = data1_r;
      if (seen_eff < LEN_W'(MAX_PATTERN)) begin
        seen_nxt = seen_eff + LEN_W'(1);
      end
      if (off_eff != '1) begin
        off_nxt = off_eff + OFF_W'(1);
      end
    end
  end

  mbps_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
    .pat    (pat),
    .window (win_nxt),
    .hit    (win_hit)
  );

  assign hit       = live && (seen_nxt >= pat.len) && win_hit;
  assign res_en    = hit || (live && last1_r);
  assign done_nxt  = done_eff || res_en;
  assign start_off = {1'b0, off_eff} + (OFF_W+1)'(1) - (OFF_W+1)'(pat.len);
  assign res_addr  = base_eff + ADDR_W'(start_off[OFF_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      off_r  <= '0;
      base_r <= '0;
      done_r <= 1'b0;
    end else if (adv1) begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      off_r  <= off_nxt;
      base_r <= base_eff;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1) begin
      out_valid_r <= res_en;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && res_en) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? res_addr : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_address = out_addr_r;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r && !done_r)
    else $error("valid flags or region state not cleared by reset");

  a_no_result_when_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && !res_en) |=> !out_valid_r)
    else $error("result shown for an item that gives none");

  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv1))
    else $error("result appeared without an item leaving the input register");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_addr_r == '0))
    else $error("not-found result carries a nonzero address");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    adv1 |=> (seen_r <= LEN_W'(MAX_PATTERN)))
    else $error("byte count beyond window depth");

endmodule
